// ===== design/tosp_pkg.sv =====
// shared types and constants for the one-axis segment planner
// used by every module of the planner; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tosp_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 8;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [63:0] RAD_CAP  = 64'h8000_0000_0000_0000;
    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    // segment kinds
    localparam logic [2:0] KIND_REV_BRAKE = 3'd0;
    localparam logic [2:0] KIND_ACC_LIMIT = 3'd1;
    localparam logic [2:0] KIND_ACC_PEAK  = 3'd2;
    localparam logic [2:0] KIND_CRUISE    = 3'd3;
    localparam logic [2:0] KIND_BRAKE     = 3'd4;
    localparam logic [2:0] KIND_OVERSPEED = 3'd5;
    localparam logic [2:0] KIND_NONE      = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_CASE  = 2'd1;
    localparam logic [1:0] STAT_SEG_LIMIT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VEL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ACC_LIMIT = 2'd1;
    localparam logic [1:0] CFG_POS_TOL   = 2'd2;
    localparam logic [1:0] CFG_VEL_TOL   = 2'd3;

    typedef struct packed {
        logic signed [31:0] start_pos;
        logic signed [31:0] start_vel;
        logic signed [31:0] target_pos;
    } item_t;

    typedef struct packed {
        logic [30:0] vel_limit;
        logic [30:0] acc_limit;
        logic [15:0] pos_tol;
        logic [15:0] vel_tol;
    } limits_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] effort;
        logic [30:0]        duration;
        logic signed [31:0] end_pos;
        logic signed [31:0] end_vel;
        logic [30:0]        elapsed;
        logic [1:0]         status;
        logic               last;
    } segment_t;

endpackage

`default_nettype wire

// ===== design/tosp_front.sv =====
// command front end: takes move commands and holds them in a two-word queue
// depends on tosp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tosp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire tosp_pkg::item_t cmd,
    output logic                busy,
    output logic                q_valid,
    output tosp_pkg::item_t     q_item,
    input  wire logic           q_take
);
    import tosp_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_take && q_valid;
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== design/tosp_div.sv =====
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// depends on tosp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tosp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [63:0]      quot
);
    import tosp_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] q_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign fits   = (rem_sh >= {1'b0, den_reg});
    assign done   = done_reg;
    assign quot   = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], fits};
        end
    end

endmodule

`default_nettype wire

// ===== design/tosp_sqrt.sv =====
// floored integer square root of a 64-bit value, one result bit a cycle
// depends on tosp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tosp_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [63:0] rad,
    output logic             done,
    output logic [31:0]      root
);
    import tosp_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [64:0] trial;
    logic        fits;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};
    assign fits  = ({1'b0, x_reg} >= trial);
    assign done  = done_reg;
    assign root  = r_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            x_reg   <= rad;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                x_reg <= x_reg - trial[63:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

// ===== design/tosp_back.sv =====
// planning sequencer: runs passes over one command, one segment per pass,
// with a shared multiplier, divider and square root unit
// depends on tosp_pkg, tosp_div, tosp_sqrt
`timescale 1ns / 1ps
`default_nettype none

module tosp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tosp_pkg::limits_t lim,
    input  wire logic             q_valid,
    input  wire tosp_pkg::item_t  q_item,
    output logic                  q_take,
    output logic                  strobe,
    output tosp_pkg::segment_t    seg
);
    import tosp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SQU, S_TMP_GO, S_TMP_W, S_CLASS, S_FA, S_SQ_GO,
        S_SQ_W, S_PKSEL, S_SQX, S_DIST_GO, S_DIST_W, S_DUR_GO, S_DUR_W, S_UPD
    } state_t;

    state_t state_reg;

    logic signed [31:0] p_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] tgt_reg;
    logic [30:0]        el_reg;
    logic [SEG_W-1:0]   n_reg;
    logic               neg_reg;
    logic               back_reg;
    logic [31:0]        u_reg;
    logic [32:0]        f_reg;
    logic [63:0]        uu_reg;
    logic [63:0]        tmp_reg;
    logic [32:0]        diff_reg;
    logic [2:0]         kind_reg;
    logic [31:0]        xsel_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        dist_reg;
    logic [63:0]        dur_reg;
    segment_t           pend_reg;
    segment_t           out_reg;
    logic               strobe_reg;

    // effective limits, zero taken as one
    logic [30:0] acc;
    logic [30:0] vlim;
    assign acc  = (lim.acc_limit == '0) ? 31'd1 : lim.acc_limit;
    assign vlim = (lim.vel_limit == '0) ? 31'd1 : lim.vel_limit;

    // pass entry checks
    logic signed [32:0] wf;
    logic               neg_c;
    logic [32:0]        ad;
    logic signed [32:0] v33;
    logic signed [32:0] v0;
    logic [32:0]        u_c;
    logic [32:0]        av;
    logic               arrived;

    always_comb
    begin
        wf      = $signed({tgt_reg[31], tgt_reg}) - $signed({p_reg[31], p_reg});
        neg_c   = wf[32];
        ad      = neg_c ? 33'(-wf) : 33'(wf);
        v33     = $signed({v_reg[31], v_reg});
        v0      = neg_c ? -v33 : v33;
        u_c     = v0[32] ? 33'(-v0) : 33'(v0);
        av      = v_reg[31] ? 33'(-v33) : 33'(v33);
        arrived = (ad <= {17'b0, lim.pos_tol}) && (av <= {17'b0, lim.vel_tol});
    end

    // classification after the stopping distance is known
    logic signed [65:0] diff_c;
    logic               gt;
    assign diff_c = $signed({33'b0, f_reg}) - $signed({2'b0, tmp_reg});
    assign gt     = diff_c > $signed({50'b0, lim.pos_tol});

    // shared multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    always_comb
    begin
        unique case (state_reg)
            S_FA:
            begin
                mul_a = f_reg;
                mul_b = {1'b0, acc};
            end
            S_SQX:
            begin
                mul_a = {1'b0, xsel_reg};
                mul_b = xsel_reg;
            end
            default:
            begin
                mul_a = {1'b0, u_reg};
                mul_b = u_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // radicand, saturating at the cap
    logic [64:0] rad_s;
    logic [63:0] rad;
    assign rad_s = {1'b0, prod_reg} + {2'b0, uu_reg[63:1]};
    assign rad   = (rad_s > {1'b0, RAD_CAP}) ? RAD_CAP : rad_s[63:0];

    // divider operands
    logic [32:0] dv;
    logic        div_go;
    logic [63:0] div_num;
    logic [31:0] div_den;
    logic        div_done;
    logic [63:0] div_q;

    always_comb
    begin
        unique case (kind_reg)
            KIND_CRUISE:                  dv = diff_reg;
            KIND_ACC_LIMIT, KIND_ACC_PEAK: dv = 33'({1'b0, xsel_reg} - {1'b0, u_reg});
            KIND_OVERSPEED:               dv = 33'({1'b0, u_reg} - {1'b0, xsel_reg});
            default:                      dv = {1'b0, u_reg};
        endcase

        div_go = 1'b0;
        unique case (state_reg)
            S_TMP_GO:
            begin
                div_go  = 1'b1;
                div_num = uu_reg;
                div_den = {acc, 1'b0};
            end
            S_DIST_GO:
            begin
                div_go  = 1'b1;
                div_num = (kind_reg == KIND_OVERSPEED) ? (uu_reg - prod_reg)
                                                       : (prod_reg - uu_reg);
                div_den = {acc, 1'b0};
            end
            default:
            begin
                div_go  = (state_reg == S_DUR_GO);
                div_num = 64'(dv) << FRAC_BITS;
                div_den = (kind_reg == KIND_CRUISE) ? {1'b0, vlim} : {1'b0, acc};
            end
        endcase
    end

    tosp_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_q)
    );

    logic        sq_go;
    logic        sq_done;
    logic [31:0] sq_root;
    assign sq_go = (state_reg == S_SQ_GO);

    tosp_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (sq_go),
        .rad  (rad),
        .done (sq_done),
        .root (sq_root)
    );

    // segment end state
    logic               dneg;
    logic signed [65:0] delta;
    logic signed [65:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic               eff_pos;
    logic signed [31:0] eff_c;
    logic [31:0]        vmag;
    logic signed [31:0] vel_c;
    logic [30:0]        dur_sat;
    logic [31:0]        el_sum;
    logic [30:0]        el_sat;

    always_comb
    begin
        dneg    = back_reg ^ neg_reg;
        delta   = dneg ? -$signed({2'b0, dist_reg}) : $signed({2'b0, dist_reg});
        pos_sum = $signed({{34{p_reg[31]}}, p_reg}) + delta;
        if (pos_sum > 66'sd2147483647)
        begin
            pos_sat = 32'sh7FFF_FFFF;
        end
        else if (pos_sum < -66'sd2147483648)
        begin
            pos_sat = 32'sh8000_0000;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end

        eff_pos = (kind_reg == KIND_REV_BRAKE) || (kind_reg == KIND_ACC_LIMIT)
               || (kind_reg == KIND_ACC_PEAK);
        if (kind_reg == KIND_CRUISE)
        begin
            eff_c = '0;
        end
        else if (eff_pos == neg_reg)
        begin
            eff_c = -$signed({1'b0, acc});
        end
        else
        begin
            eff_c = $signed({1'b0, acc});
        end

        vmag  = ((kind_reg == KIND_REV_BRAKE) || (kind_reg == KIND_BRAKE)) ? '0 : xsel_reg;
        vel_c = neg_reg ? -$signed(vmag) : $signed(vmag);

        dur_sat = (dur_reg[63:31] != '0) ? TIME_MAX : dur_reg[30:0];
        el_sum  = {1'b0, el_reg} + {1'b0, dur_sat};
        el_sat  = el_sum[31] ? TIME_MAX : el_sum[30:0];
    end

    assign q_take = (state_reg == S_IDLE) && q_valid;
    assign strobe = strobe_reg;
    assign seg    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            n_reg      <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        p_reg     <= q_item.start_pos;
                        v_reg     <= q_item.start_vel;
                        tgt_reg   <= q_item.target_pos;
                        el_reg    <= '0;
                        n_reg     <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (arrived)
                    begin
                        strobe_reg <= 1'b1;
                        if (n_reg == '0)
                        begin
                            out_reg.kind     <= KIND_NONE;
                            out_reg.effort   <= '0;
                            out_reg.duration <= '0;
                            out_reg.end_pos  <= p_reg;
                            out_reg.end_vel  <= v_reg;
                            out_reg.elapsed  <= '0;
                            out_reg.status   <= STAT_OK;
                            out_reg.last     <= 1'b1;
                        end
                        else
                        begin
                            out_reg      <= pend_reg;
                            out_reg.last <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (n_reg == SEG_W'(MAX_SEGMENTS))
                    begin
                        strobe_reg     <= 1'b1;
                        out_reg        <= pend_reg;
                        out_reg.status <= STAT_SEG_LIMIT;
                        out_reg.last   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        if (n_reg != '0)
                        begin
                            strobe_reg <= 1'b1;
                            out_reg    <= pend_reg;
                        end
                        neg_reg   <= neg_c;
                        back_reg  <= v0[32];
                        u_reg     <= u_c[31:0];
                        f_reg     <= ad;
                        state_reg <= S_SQU;
                    end
                end
                S_SQU:
                begin
                    uu_reg    <= mul_p[63:0];
                    state_reg <= S_TMP_GO;
                end
                S_TMP_GO:
                begin
                    state_reg <= S_TMP_W;
                end
                S_TMP_W:
                begin
                    if (div_done)
                    begin
                        tmp_reg   <= div_q;
                        state_reg <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    diff_reg <= diff_c[32:0];
                    xsel_reg <= {1'b0, vlim};
                    priority if (back_reg)
                    begin
                        kind_reg  <= KIND_REV_BRAKE;
                        dist_reg  <= tmp_reg;
                        state_reg <= S_DUR_GO;
                    end
                    else if ((u_reg < {1'b0, vlim}) && gt)
                    begin
                        state_reg <= S_FA;
                    end
                    else if ((u_reg == {1'b0, vlim}) && gt)
                    begin
                        kind_reg  <= KIND_CRUISE;
                        dist_reg  <= 64'(diff_c[32:0]);
                        state_reg <= S_DUR_GO;
                    end
                    else if (u_reg <= {1'b0, vlim})
                    begin
                        kind_reg  <= KIND_BRAKE;
                        dist_reg  <= tmp_reg;
                        state_reg <= S_DUR_GO;
                    end
                    else
                    begin
                        kind_reg  <= KIND_OVERSPEED;
                        state_reg <= S_SQX;
                    end
                end
                S_FA:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_SQ_GO;
                end
                S_SQ_GO:
                begin
                    state_reg <= S_SQ_W;
                end
                S_SQ_W:
                begin
                    if (sq_done)
                    begin
                        xsel_reg  <= sq_root;
                        state_reg <= S_PKSEL;
                    end
                end
                S_PKSEL:
                begin
                    if (xsel_reg > {1'b0, vlim})
                    begin
                        kind_reg <= KIND_ACC_LIMIT;
                        xsel_reg <= {1'b0, vlim};
                    end
                    else
                    begin
                        kind_reg <= KIND_ACC_PEAK;
                        if (xsel_reg < u_reg)
                        begin
                            xsel_reg <= u_reg;
                        end
                    end
                    state_reg <= S_SQX;
                end
                S_SQX:
                begin
                    // square of the end speed, reused as the distance numerator term
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_DIST_GO;
                end
                S_DIST_GO:
                begin
                    state_reg <= S_DIST_W;
                end
                S_DIST_W:
                begin
                    if (div_done)
                    begin
                        dist_reg  <= div_q;
                        state_reg <= S_DUR_GO;
                    end
                end
                S_DUR_GO:
                begin
                    state_reg <= S_DUR_W;
                end
                S_DUR_W:
                begin
                    if (div_done)
                    begin
                        dur_reg   <= div_q;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    p_reg             <= pos_sat;
                    v_reg             <= vel_c;
                    el_reg            <= el_sat;
                    n_reg             <= n_reg + SEG_W'(1);
                    pend_reg.kind     <= kind_reg;
                    pend_reg.effort   <= eff_c;
                    pend_reg.duration <= dur_sat;
                    pend_reg.end_pos  <= pos_sat;
                    pend_reg.end_vel  <= vel_c;
                    pend_reg.elapsed  <= el_sat;
                    pend_reg.status   <= STAT_OK;
                    pend_reg.last     <= 1'b0;
                    state_reg         <= S_CHECK;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/time_optimal_segment_planner.sv =====
// top level of the one-axis minimum-time segment planner
// depends on tosp_pkg, tosp_front, tosp_back
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  Commands: drive start_pos, start_vel, target_pos and raise start; the word is
//  taken at a clock edge where start is high and busy is low. Two commands can
//  wait in the queue while one is being planned; busy is high while it is full.
//  Results: each segment appears for one cycle with strobe high; the receiver
//  cannot hold it off. A plan gives one to MAX_SEGMENTS words, the final one
//  with last set; status 2 marks a plan cut off at the segment limit.
//  Sequencing: a segment takes one pass of the sequencer, which runs the divider
//  at most three times and the square root at most once; a segment is shown
//  when the next pass has begun.
//  Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//  ready; write only while no plan is running. Reset restores the default
//  limits and empties the queue.

module time_optimal_segment_planner (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] start_pos,
    input  wire logic signed [31:0] start_vel,
    input  wire logic signed [31:0] target_pos,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    output logic                    strobe,
    output logic [2:0]              segment_kind,
    output logic signed [31:0]      effort,
    output logic [30:0]             duration,
    output logic signed [31:0]      end_pos,
    output logic signed [31:0]      end_vel,
    output logic [30:0]             elapsed_time,
    output logic [1:0]              status,
    output logic                    last
);
    import tosp_pkg::*;

    limits_t  lim_reg;
    item_t    cmd;
    item_t    q_item;
    logic     q_valid;
    logic     q_take;
    segment_t seg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.vel_limit <= 31'd65536;
            lim_reg.acc_limit <= 31'd65536;
            lim_reg.pos_tol   <= 16'd1;
            lim_reg.vel_tol   <= 16'd66;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VEL_LIMIT: lim_reg.vel_limit <= cfg_data;
                CFG_ACC_LIMIT: lim_reg.acc_limit <= cfg_data;
                CFG_POS_TOL:   lim_reg.pos_tol   <= cfg_data[15:0];
                CFG_VEL_TOL:   lim_reg.vel_tol   <= cfg_data[15:0];
                default:       lim_reg           <= lim_reg;
            endcase
        end
    end

    assign cmd.start_pos  = start_pos;
    assign cmd.start_vel  = start_vel;
    assign cmd.target_pos = target_pos;

    tosp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_take (q_take)
    );

    tosp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .lim    (lim_reg),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_take (q_take),
        .strobe (strobe),
        .seg    (seg)
    );

    assign segment_kind = seg.kind;
    assign effort       = seg.effort;
    assign duration     = seg.duration;
    assign end_pos      = seg.end_pos;
    assign end_vel      = seg.end_vel;
    assign elapsed_time = seg.elapsed;
    assign status       = seg.status;
    assign last         = seg.last;

    // segments of a plan are a full pass apart
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("segment words on consecutive cycles");

    a_limit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == STAT_SEG_LIMIT)) |-> last)
        else $error("segment limit word not marked last");

    a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (segment_kind == KIND_NONE)) |-> (last && (duration == '0)
            && (elapsed_time == '0)))
        else $error("arrived word malformed");

endmodule

`default_nettype wire

// ===== verif/tosp_checker.sv =====
// segment checker for the one-axis planner: tracks the limit registers,
// predicts every segment word of an accepted command and compares the results
// depends on tosp_pkg
`timescale 1ns / 1ps

module tosp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] start_pos,
    input  logic signed [31:0] start_vel,
    input  logic signed [31:0] target_pos,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               strobe,
    input  logic [2:0]         segment_kind,
    input  logic signed [31:0] effort,
    input  logic [30:0]        duration,
    input  logic signed [31:0] end_pos,
    input  logic signed [31:0] end_vel,
    input  logic [30:0]        elapsed_time,
    input  logic [1:0]         status,
    input  logic               last,
    output int                 fail_count,
    output int                 pending
);
    import tosp_pkg::*;

    limits_t  lim;
    segment_t segment_q[$];

    function automatic longint unsigned sqrt_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned time_of(input longint unsigned dv,
                                                input longint unsigned a);
        return (dv << FRAC_BITS) / a;
    endfunction

    task automatic plan_move(input logic signed [31:0] sp, input logic signed [31:0] sv,
                             input logic signed [31:0] tp);
        longint p, v, tgt, wf, ad, av, v0, eff, vend, delta, diff, pt;
        longint unsigned acc, vmax, u, dist_f, stop_d, s, pk, dur, seg_len, el;
        bit neg, back, done;
        logic [2:0] kind;
        segment_t segs[MAX_SEGMENTS];
        int n;
        p = sp;
        v = sv;
        tgt = tp;
        acc = (lim.acc_limit != 0) ? lim.acc_limit : 1;
        vmax = (lim.vel_limit != 0) ? lim.vel_limit : 1;
        pt = lim.pos_tol;
        el = 0;
        n = 0;
        done = 0;
        while (!done)
        begin
            wf = tgt - p;
            ad = (wf < 0) ? -wf : wf;
            av = (v < 0) ? -v : v;
            neg = wf < 0;
            v0 = neg ? -v : v;
            back = 0;
            if (ad <= pt && av <= longint'(lim.vel_tol))
            begin
                if (n == 0)
                begin
                    segs[0] = '{KIND_NONE, 32'sd0, 31'd0, p[31:0], v[31:0], 31'd0,
                                STAT_OK, 1'b1};
                    n = 1;
                end
                else
                    segs[n-1].last = 1'b1;
                done = 1;
            end
            else if (n >= MAX_SEGMENTS)
            begin
                segs[n-1].status = STAT_SEG_LIMIT;
                segs[n-1].last = 1'b1;
                done = 1;
            end
            else
            begin
                if (v0 < 0)
                begin
                    u = -v0;
                    kind = KIND_REV_BRAKE;
                    eff = acc;
                    vend = 0;
                    dur = time_of(u, acc);
                    seg_len = (u * u) / (2 * acc);
                    back = 1;
                end
                else
                begin
                    u = v0;
                    dist_f = ad;
                    stop_d = (u * u) / (2 * acc);
                    diff = longint'(dist_f) - longint'(stop_d);
                    if (u < vmax && diff > pt)
                    begin
                        if (dist_f > RAD_CAP / acc)
                            s = RAD_CAP;
                        else
                        begin
                            s = dist_f * acc + (u * u) / 2;
                            if (s > RAD_CAP)
                                s = RAD_CAP;
                        end
                        pk = sqrt_floor(s);
                        eff = acc;
                        if (pk > vmax)
                        begin
                            kind = KIND_ACC_LIMIT;
                            vend = vmax;
                            dur = time_of(vmax - u, acc);
                            seg_len = (vmax * vmax - u * u) / (2 * acc);
                        end
                        else
                        begin
                            if (pk < u)
                                pk = u;
                            kind = KIND_ACC_PEAK;
                            vend = pk;
                            dur = time_of(pk - u, acc);
                            seg_len = (pk * pk - u * u) / (2 * acc);
                        end
                    end
                    else if (u == vmax && diff > pt)
                    begin
                        kind = KIND_CRUISE;
                        eff = 0;
                        vend = vmax;
                        seg_len = diff;
                        dur = time_of(seg_len, vmax);
                    end
                    else if (u <= vmax)
                    begin
                        kind = KIND_BRAKE;
                        eff = -longint'(acc);
                        vend = 0;
                        seg_len = stop_d;
                        dur = time_of(u, acc);
                    end
                    else
                    begin
                        kind = KIND_OVERSPEED;
                        eff = -longint'(acc);
                        vend = vmax;
                        seg_len = (u * u - vmax * vmax) / (2 * acc);
                        dur = time_of(u - vmax, acc);
                    end
                end
                delta = back ? -longint'(seg_len) : longint'(seg_len);
                if (neg)
                begin
                    delta = -delta;
                    eff = -eff;
                    vend = -vend;
                end
                p = p + delta;
                // positions stay inside 32 signed bits between passes
                if (p > 64'sh7FFF_FFFF)
                    p = 64'sh7FFF_FFFF;
                else if (p < -64'sh8000_0000)
                    p = -64'sh8000_0000;
                v = vend;
                if (dur > TIME_MAX)
                    dur = TIME_MAX;
                el = el + dur;
                if (el > TIME_MAX)
                    el = TIME_MAX;
                segs[n] = '{kind, eff[31:0], dur[30:0], p[31:0], v[31:0], el[30:0],
                            STAT_OK, 1'b0};
                n++;
            end
        end
        for (int i = 0; i < n; i++)
            segment_q = {segment_q, segs[i]};
    endtask

    task automatic check_word();
        segment_t exp_seg;
        if (segment_q.size() == 0)
        begin
            $error("segment word with none expected: kind %0d", segment_kind);
            fail_count++;
            return;
        end
        exp_seg = segment_q.pop_front();
        if (segment_kind !== exp_seg.kind)
        begin
            $error("segment_kind: expected %0d, got %0d", exp_seg.kind, segment_kind);
            fail_count++;
        end
        if (effort !== exp_seg.effort)
        begin
            $error("effort: expected %0d, got %0d", exp_seg.effort, effort);
            fail_count++;
        end
        if (duration !== exp_seg.duration)
        begin
            $error("duration: expected %0d, got %0d", exp_seg.duration, duration);
            fail_count++;
        end
        if (end_pos !== exp_seg.end_pos)
        begin
            $error("end_pos: expected %0d, got %0d", exp_seg.end_pos, end_pos);
            fail_count++;
        end
        if (end_vel !== exp_seg.end_vel)
        begin
            $error("end_vel: expected %0d, got %0d", exp_seg.end_vel, end_vel);
            fail_count++;
        end
        if (elapsed_time !== exp_seg.elapsed)
        begin
            $error("elapsed_time: expected %0d, got %0d", exp_seg.elapsed, elapsed_time);
            fail_count++;
        end
        if (status !== exp_seg.status)
        begin
            $error("status: expected %0d, got %0d", exp_seg.status, status);
            fail_count++;
        end
        if (last !== exp_seg.last)
        begin
            $error("last: expected %0d, got %0d", exp_seg.last, last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim = '{31'd65536, 31'd65536, 16'd1, 16'd66};
            segment_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (strobe)
                check_word();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VEL_LIMIT: lim.vel_limit = cfg_data;
                    CFG_ACC_LIMIT: lim.acc_limit = cfg_data;
                    CFG_POS_TOL:   lim.pos_tol = cfg_data[15:0];
                    CFG_VEL_TOL:   lim.vel_tol = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                plan_move(start_pos, start_vel, target_pos);
            pending = segment_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// testbench top for the one-axis segment planner: clock, reset, limit
// settings and move commands; checking is done in tosp_checker
// depends on tosp_pkg, tosp_checker, time_optimal_segment_planner
`timescale 1ns / 1ps

module tb;
    import tosp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] target_pos;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               strobe;
    logic [2:0]         segment_kind;
    logic signed [31:0] effort;
    logic [30:0]        duration;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic [30:0]        elapsed_time;
    logic [1:0]         status;
    logic               last;
    int                 fail_count;
    int                 pending;
    bit                 calm;

    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;

    time_optimal_segment_planner dut (.*);

    tosp_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic idle_gap();
        if (!calm)
            while ($urandom_range(0, 99) < 20)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
    endtask

    task automatic send_move(input logic signed [31:0] sp, input logic signed [31:0] sv,
                             input logic signed [31:0] tp);
        bit taken;
        idle_gap();
        start <= 1'b1;
        start_pos <= sp;
        start_vel <= sv;
        target_pos <= tp;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    // let every expected word arrive, then a pass or so of slack
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
    endtask

    task automatic set_limits(input logic [30:0] vl, input logic [30:0] al,
                              input logic [15:0] pt, input logic [15:0] vt);
        drain();
        write_reg(CFG_VEL_LIMIT, vl);
        write_reg(CFG_ACC_LIMIT, al);
        write_reg(CFG_POS_TOL, {15'd0, pt});
        write_reg(CFG_VEL_TOL, {15'd0, vt});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_move();
        logic signed [31:0] sp, sv, tp;
        if ($urandom_range(0, 9) < 7)
        begin
            sp = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            sv = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            if ($urandom_range(0, 4) == 0)
                tp = sp + $signed($urandom_range(0, 16)) - 8;
            else
                tp = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        end
        else
        begin
            sp = $urandom;
            sv = $urandom;
            tp = $urandom;
        end
        send_move(sp, sv, tp);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        start_pos = '0;
        start_vel = '0;
        target_pos = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VEL_LIMIT;
        cfg_data = '0;
        calm = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: arrived, each segment kind, both directions, extremes
        send_move(0, 0, 0);
        send_move(0, 50, 1);
        send_move(0, 0, 10 * ONE);
        send_move(0, -3 * ONE, 5 * ONE);
        send_move(0, 5 * ONE, 100 * ONE);
        send_move(100 * ONE, 0, 0);
        send_move(PMIN, 0, PMAX);
        send_move(PMAX, PMAX, PMIN);
        send_move(PMIN, PMIN, PMIN);
        send_move(-32'sd1, -32'sd1, 32'sh5555_5555);

        // zero limits with no tolerance, long plans run into the segment cap
        set_limits(31'd0, 31'd0, 16'd0, 16'd0);
        send_move(0, 0, 3 * ONE);
        send_move(0, 7, -ONE);
        send_move(ONE, -ONE, 0);

        // largest limits and tolerances
        set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_move(0, 0, PMAX);
        send_move(PMAX, PMIN, PMIN);
        send_move(0, 32'sh0000_FFFF, 32'sh0000_FFFF);
        send_move(32'sh2AAA_AAAA, 32'sh7000_0000, -32'sh2AAA_AAAA);

        set_limits(31'd1, 31'd1, 16'd0, 16'd0);
        send_move(0, 0, 5);
        send_move(0, 3, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            set_limits(31'($urandom_range(1 << 12, 1 << 21)),
                       31'($urandom_range(1 << 12, 1 << 21)),
                       16'($urandom_range(0, 255)), 16'($urandom_range(0, 1000)));
            calm = (phase == 2);
            for (int i = 0; i < 28; i++)
                random_move();
        end
        set_limits(31'($urandom), 31'($urandom), 16'($urandom), 16'($urandom));
        for (int i = 0; i < 10; i++)
            random_move();

        drain();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
